>>> hw/rtl/s2cd_pkg.sv
// Package for the seconds-to-calendar-date converter.
// Holds the pipeline depth, the divisors and reciprocals of the constant
// divisions, and the month start table. No dependencies.
`default_nettype none

package s2cd_pkg;

    // Number of register stages from the input word to the output register.
    localparam int unsigned NUM_STAGES = 13;

    // Seconds per day is 86400 = 128 * 675; the low 7 bits pass straight through.
    localparam logic [9:0]  DAY_BLK_DIV  = 10'd675;
    localparam logic [15:0] DAY_RECIP    = 16'd49710;   // floor(2^25 / 675)

    // Julian day number of the epoch plus the algorithm's offset.
    localparam logic [21:0] JDN_BASE     = 22'd2483589;

    // Days in 400 Gregorian years.
    localparam logic [17:0] DAYS_400Y    = 18'd146097;
    localparam logic [6:0]  CENT_RECIP   = 7'd114;      // floor(2^24 / 146097)

    // Days in 4 Julian years.
    localparam logic [10:0] DAYS_4Y      = 11'd1461;
    localparam logic [7:0]  YEAR4_RECIP  = 8'd179;      // floor(2^18 / 1461)

    // Day-of-year to month: (5 * a + 2) / 153.
    localparam logic [7:0]  MON_BLK_DIV  = 8'd153;
    localparam logic [3:0]  MON_RECIP    = 4'd13;       // floor(2^11 / 153)

    // Seconds per hour is 3600 = 16 * 225.
    localparam logic [7:0]  HOUR_BLK_DIV = 8'd225;
    localparam logic [5:0]  HOUR_RECIP   = 6'd36;       // floor(2^13 / 225)

    // Seconds per minute is 60 = 4 * 15.
    localparam logic [3:0]  MIN_BLK_DIV  = 4'd15;
    localparam logic [6:0]  MIN_RECIP    = 7'd68;       // floor(2^10 / 15)

    // Year assembly.
    localparam logic [6:0]  YEARS_PER_CENT = 7'd100;
    localparam logic [12:0] YEAR_BIAS      = 13'd4800;
    localparam logic [12:0] RTC_BASE_SUM   = 13'd6800;  // year bias plus 2000

    // Month index counts from March; indexes from this one fall in the next year.
    localparam logic [3:0]  MON_WRAP     = 4'd10;
    localparam logic [3:0]  MON_WRAP_SUB = 4'd9;
    localparam logic [3:0]  MON_MAR_ADD  = 4'd3;

    // Days before the start of each month, counted from March 1:
    // floor((153 * mo + 2) / 5).
    function automatic logic [8:0] month_start(input logic [3:0] mo);
        logic [8:0] days;
        begin
            case (mo)
                4'd0:    days = 9'd0;
                4'd1:    days = 9'd31;
                4'd2:    days = 9'd61;
                4'd3:    days = 9'd92;
                4'd4:    days = 9'd122;
                4'd5:    days = 9'd153;
                4'd6:    days = 9'd184;
                4'd7:    days = 9'd214;
                4'd8:    days = 9'd245;
                4'd9:    days = 9'd275;
                4'd10:   days = 9'd306;
                4'd11:   days = 9'd337;
                default: days = 9'd0;
            endcase
            return days;
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/s2cd_pipe_ctrl.sv
// Flow control of the converter pipeline: valid bits per stage and the
// common advance signal. Depends on s2cd_pkg for the stage count.
`default_nettype none

module s2cd_pipe_ctrl
    import s2cd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  wire  i_out_ready,
    output logic o_advance,
    output logic o_out_valid
);

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;

    // The whole pipeline moves unless a finished word waits at the output.
    assign o_advance   = ~r_valid[NUM_STAGES-1] | i_out_ready;
    assign o_out_valid = r_valid[NUM_STAGES-1];

    // Valid bits shift along with the data words.
    always_comb begin
        n_valid = {r_valid[NUM_STAGES-2:0], i_in_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (o_advance) begin
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/seconds_to_calendar_date_top.sv
// Top level of the seconds-to-calendar-date converter: datapath stages.
// Depends on s2cd_pkg and s2cd_pipe_ctrl.
`default_nettype none

// Converts a 32-bit count of seconds since 2000-01-01 00:00:00 into time of
// day and Gregorian date (day, month, full year, and year minus 2000). The
// block is a 13-stage pipeline that takes one word per cycle while it does not
// hold; each word passes through the stage registers into the output register.
// The divisions by constants are reciprocal multiplies followed by one
// correction step, each spread over three stages; the Julian-day chain (days,
// 400-year cycles, 4-year cycles, months) sets the depth. When the output word
// is not taken the whole pipeline holds, so input ready follows output ready
// whenever the output register is full. Reset only clears the valid bits.
module seconds_to_calendar_date_top
    import s2cd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [31:0] i_seconds_count,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [5:0]  o_second_of_minute,
    output logic [5:0]  o_minute_of_hour,
    output logic [4:0]  o_hour_of_day,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_of_year,
    output logic [11:0] o_full_year,
    output logic [7:0]  o_rtc_year
);

    logic w_advance;

    s2cd_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_advance   (w_advance),
        .o_out_valid (o_out_valid)
    );

    assign o_in_ready = w_advance;

    // Stage registers.
    logic [31:0] r_s1_secs;
    logic [15:0] r_s1_dq0;
    logic [15:0] r_s2_dq0;
    logic [10:0] r_s2_r0;
    logic [6:0]  r_s2_lo7;
    logic [15:0] r_s3_days;
    logic [16:0] r_s3_tod;
    logic [23:0] r_s4_cx;
    logic [6:0]  r_s4_cq0;
    logic [16:0] r_s4_tod;
    logic [4:0]  r_s4_hq0;
    logic [6:0]  r_s5_cq0;
    logic [18:0] r_s5_cr0;
    logic [4:0]  r_s5_hq0;
    logic [8:0]  r_s5_hr0;
    logic [3:0]  r_s5_tlo4;
    logic [6:0]  r_s6_cent;
    logic [15:0] r_s6_a2;
    logic [4:0]  r_s6_hour;
    logic [11:0] r_s6_hrem;
    logic [6:0]  r_s7_cent;
    logic [17:0] r_s7_yx;
    logic [6:0]  r_s7_yq0;
    logic [4:0]  r_s7_hour;
    logic [11:0] r_s7_hrem;
    logic [5:0]  r_s7_mq0;
    logic [6:0]  r_s8_cent;
    logic [6:0]  r_s8_yq0;
    logic [11:0] r_s8_yr0;
    logic [4:0]  r_s8_hour;
    logic [5:0]  r_s8_mq0;
    logic [4:0]  r_s8_mr0;
    logic [1:0]  r_s8_slo2;
    logic [6:0]  r_s9_cent;
    logic [6:0]  r_s9_yr4;
    logic [8:0]  r_s9_a3;
    logic [4:0]  r_s9_hour;
    logic [5:0]  r_s9_minute;
    logic [5:0]  r_s9_second;
    logic [6:0]  r_s10_cent;
    logic [6:0]  r_s10_yr4;
    logic [8:0]  r_s10_a3;
    logic [10:0] r_s10_mx;
    logic [3:0]  r_s10_mo0;
    logic [4:0]  r_s10_hour;
    logic [5:0]  r_s10_minute;
    logic [5:0]  r_s10_second;
    logic [6:0]  r_s11_cent;
    logic [6:0]  r_s11_yr4;
    logic [8:0]  r_s11_a3;
    logic [3:0]  r_s11_mo0;
    logic [8:0]  r_s11_mr0;
    logic [4:0]  r_s11_hour;
    logic [5:0]  r_s11_minute;
    logic [5:0]  r_s11_second;
    logic [6:0]  r_s12_cent;
    logic [6:0]  r_s12_yr4;
    logic [8:0]  r_s12_a3;
    logic [3:0]  r_s12_mo;
    logic [4:0]  r_s12_hour;
    logic [5:0]  r_s12_minute;
    logic [5:0]  r_s12_second;
    logic [5:0]  r_second;
    logic [5:0]  r_minute;
    logic [4:0]  r_hour;
    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [11:0] r_year;
    logic [7:0]  r_rtc;

    // Next values and intermediate terms.
    logic [40:0] s1_prod;
    logic [15:0] n_s1_dq0;
    logic [25:0] s2_prod;
    logic [25:0] s2_diff;
    logic [10:0] n_s2_r0;
    logic        s3_carry;
    logic [10:0] s3_rdiff;
    logic [9:0]  s3_rem;
    logic [15:0] n_s3_days;
    logic [16:0] n_s3_tod;
    logic [21:0] s4_jdn;
    logic [23:0] n_s4_cx;
    logic [30:0] s4_cprod;
    logic [6:0]  n_s4_cq0;
    logic [17:0] s4_hprod;
    logic [4:0]  n_s4_hq0;
    logic [23:0] s5_cprod;
    logic [23:0] s5_cdiff;
    logic [18:0] n_s5_cr0;
    logic [12:0] s5_hprod;
    logic [12:0] s5_hdiff;
    logic [8:0]  n_s5_hr0;
    logic        s6_cc;
    logic [18:0] s6_cdiff;
    logic [17:0] s6_rc;
    logic [18:0] s6_asum;
    logic [6:0]  n_s6_cent;
    logic [15:0] n_s6_a2;
    logic        s6_hc;
    logic [8:0]  s6_hdiff;
    logic [7:0]  s6_hr;
    logic [4:0]  n_s6_hour;
    logic [11:0] n_s6_hrem;
    logic [17:0] n_s7_yx;
    logic [24:0] s7_yprod;
    logic [6:0]  n_s7_yq0;
    logic [15:0] s7_mprod;
    logic [5:0]  n_s7_mq0;
    logic [17:0] s8_yprod;
    logic [17:0] s8_ydiff;
    logic [11:0] n_s8_yr0;
    logic [9:0]  s8_mprod;
    logic [9:0]  s8_mdiff;
    logic [4:0]  n_s8_mr0;
    logic        s9_yc;
    logic [11:0] s9_ydiff;
    logic [10:0] s9_ry;
    logic [11:0] s9_asum;
    logic [6:0]  n_s9_yr4;
    logic [8:0]  n_s9_a3;
    logic        s9_mc;
    logic [4:0]  s9_mdiff;
    logic [3:0]  s9_mr;
    logic [5:0]  n_s9_minute;
    logic [5:0]  n_s9_second;
    logic [10:0] n_s10_mx;
    logic [14:0] s10_mprod;
    logic [3:0]  n_s10_mo0;
    logic [10:0] s11_mprod;
    logic [10:0] s11_mdiff;
    logic [8:0]  n_s11_mr0;
    logic        s12_mc;
    logic [3:0]  n_s12_mo;
    logic [8:0]  s13_day;
    logic        s13_wrap;
    logic [3:0]  n_month;
    logic [12:0] s13_ysum;
    logic [12:0] s13_year;
    logic [12:0] s13_rtc;
    logic [4:0]  n_day;
    logic [11:0] n_year;
    logic [7:0]  n_rtc;

    // Stages 1 to 3: whole days and second of day, via 86400 = 128 * 675.
    always_comb begin
        s1_prod  = 41'(i_seconds_count[31:7]) * 41'(DAY_RECIP);
        n_s1_dq0 = s1_prod[40:25];

        s2_prod  = 26'(r_s1_dq0) * 26'(DAY_BLK_DIV);
        s2_diff  = 26'(r_s1_secs[31:7]) - s2_prod;
        n_s2_r0  = s2_diff[10:0];

        s3_carry  = (r_s2_r0 >= 11'(DAY_BLK_DIV));
        s3_rdiff  = r_s2_r0 - 11'(DAY_BLK_DIV);
        s3_rem    = s3_carry ? s3_rdiff[9:0] : r_s2_r0[9:0];
        n_s3_days = r_s2_dq0 + 16'(s3_carry);
        n_s3_tod  = {s3_rem, r_s2_lo7};
    end

    // Stages 4 to 6: 400-year cycles and hour of day.
    always_comb begin
        s4_jdn   = 22'(r_s3_days) + JDN_BASE;
        n_s4_cx  = {s4_jdn, 2'b11};
        s4_cprod = 31'(n_s4_cx) * 31'(CENT_RECIP);
        n_s4_cq0 = s4_cprod[30:24];
        s4_hprod = 18'(r_s3_tod[16:4]) * 18'(HOUR_RECIP);
        n_s4_hq0 = s4_hprod[17:13];

        s5_cprod = 24'(r_s4_cq0) * 24'(DAYS_400Y);
        s5_cdiff = r_s4_cx - s5_cprod;
        n_s5_cr0 = s5_cdiff[18:0];
        s5_hprod = 13'(r_s4_hq0) * 13'(HOUR_BLK_DIV);
        s5_hdiff = r_s4_tod[16:4] - s5_hprod;
        n_s5_hr0 = s5_hdiff[8:0];

        // Since 146097 is 1 mod 4, the day within the cycle follows from the
        // remainder and the low bits of the cycle count.
        s6_cc     = (r_s5_cr0 >= 19'(DAYS_400Y));
        s6_cdiff  = r_s5_cr0 - 19'(DAYS_400Y);
        s6_rc     = s6_cc ? s6_cdiff[17:0] : r_s5_cr0[17:0];
        n_s6_cent = r_s5_cq0 + 7'(s6_cc);
        s6_asum   = 19'(s6_rc) + 19'(n_s6_cent[1:0]) - 19'd3;
        n_s6_a2   = s6_asum[17:2];
        s6_hc     = (r_s5_hr0 >= 9'(HOUR_BLK_DIV));
        s6_hdiff  = r_s5_hr0 - 9'(HOUR_BLK_DIV);
        s6_hr     = s6_hc ? s6_hdiff[7:0] : r_s5_hr0[7:0];
        n_s6_hour = r_s5_hq0 + 5'(s6_hc);
        n_s6_hrem = {s6_hr, r_s5_tlo4};
    end

    // Stages 7 to 9: 4-year cycles, minute and second.
    always_comb begin
        n_s7_yx  = {r_s6_a2, 2'b11};
        s7_yprod = 25'(n_s7_yx) * 25'(YEAR4_RECIP);
        n_s7_yq0 = s7_yprod[24:18];
        s7_mprod = 16'(r_s6_hrem[11:2]) * 16'(MIN_RECIP);
        n_s7_mq0 = s7_mprod[15:10];

        s8_yprod = 18'(r_s7_yq0) * 18'(DAYS_4Y);
        s8_ydiff = r_s7_yx - s8_yprod;
        n_s8_yr0 = s8_ydiff[11:0];
        s8_mprod = 10'(r_s7_mq0) * 10'(MIN_BLK_DIV);
        s8_mdiff = r_s7_hrem[11:2] - s8_mprod;
        n_s8_mr0 = s8_mdiff[4:0];

        // 1461 is also 1 mod 4, so the day of year comes the same way.
        s9_yc       = (r_s8_yr0 >= 12'(DAYS_4Y));
        s9_ydiff    = r_s8_yr0 - 12'(DAYS_4Y);
        s9_ry       = s9_yc ? s9_ydiff[10:0] : r_s8_yr0[10:0];
        n_s9_yr4    = r_s8_yq0 + 7'(s9_yc);
        s9_asum     = 12'(s9_ry) + 12'(n_s9_yr4[1:0]) - 12'd3;
        n_s9_a3     = s9_asum[10:2];
        s9_mc       = (r_s8_mr0 >= 5'(MIN_BLK_DIV));
        s9_mdiff    = r_s8_mr0 - 5'(MIN_BLK_DIV);
        s9_mr       = s9_mc ? s9_mdiff[3:0] : r_s8_mr0[3:0];
        n_s9_minute = r_s8_mq0 + 6'(s9_mc);
        n_s9_second = {s9_mr, r_s8_slo2};
    end

    // Stages 10 to 12: month index counted from March.
    always_comb begin
        n_s10_mx  = 11'({r_s9_a3, 2'b00}) + 11'(r_s9_a3) + 11'd2;
        s10_mprod = 15'(n_s10_mx) * 15'(MON_RECIP);
        n_s10_mo0 = s10_mprod[14:11];

        s11_mprod = 11'(r_s10_mo0) * 11'(MON_BLK_DIV);
        s11_mdiff = r_s10_mx - s11_mprod;
        n_s11_mr0 = s11_mdiff[8:0];

        s12_mc   = (r_s11_mr0 >= 9'(MON_BLK_DIV));
        n_s12_mo = r_s11_mo0 + 4'(s12_mc);
    end

    // Stage 13: calendar fields for the output register.
    always_comb begin
        s13_day  = 9'(r_s12_a3) - month_start(r_s12_mo) + 9'd1;
        n_day    = s13_day[4:0];
        s13_wrap = (r_s12_mo >= MON_WRAP);
        n_month  = s13_wrap ? (r_s12_mo - MON_WRAP_SUB) : (r_s12_mo + MON_MAR_ADD);
        s13_ysum = 13'(r_s12_cent) * 13'(YEARS_PER_CENT) + 13'(r_s12_yr4)
                 + 13'(s13_wrap);
        s13_year = s13_ysum - YEAR_BIAS;
        n_year   = s13_year[11:0];
        s13_rtc  = s13_ysum - RTC_BASE_SUM;
        n_rtc    = (s13_ysum >= RTC_BASE_SUM) ? s13_rtc[7:0] : 8'd0;
    end

    // Data words move one stage whenever the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s1_secs    <= i_seconds_count;
            r_s1_dq0     <= n_s1_dq0;

            r_s2_dq0     <= r_s1_dq0;
            r_s2_r0      <= n_s2_r0;
            r_s2_lo7     <= r_s1_secs[6:0];

            r_s3_days    <= n_s3_days;
            r_s3_tod     <= n_s3_tod;

            r_s4_cx      <= n_s4_cx;
            r_s4_cq0     <= n_s4_cq0;
            r_s4_tod     <= r_s3_tod;
            r_s4_hq0     <= n_s4_hq0;

            r_s5_cq0     <= r_s4_cq0;
            r_s5_cr0     <= n_s5_cr0;
            r_s5_hq0     <= r_s4_hq0;
            r_s5_hr0     <= n_s5_hr0;
            r_s5_tlo4    <= r_s4_tod[3:0];

            r_s6_cent    <= n_s6_cent;
            r_s6_a2      <= n_s6_a2;
            r_s6_hour    <= n_s6_hour;
            r_s6_hrem    <= n_s6_hrem;

            r_s7_cent    <= r_s6_cent;
            r_s7_yx      <= n_s7_yx;
            r_s7_yq0     <= n_s7_yq0;
            r_s7_hour    <= r_s6_hour;
            r_s7_hrem    <= r_s6_hrem;
            r_s7_mq0     <= n_s7_mq0;

            r_s8_cent    <= r_s7_cent;
            r_s8_yq0     <= r_s7_yq0;
            r_s8_yr0     <= n_s8_yr0;
            r_s8_hour    <= r_s7_hour;
            r_s8_mq0     <= r_s7_mq0;
            r_s8_mr0     <= n_s8_mr0;
            r_s8_slo2    <= r_s7_hrem[1:0];

            r_s9_cent    <= r_s8_cent;
            r_s9_yr4     <= n_s9_yr4;
            r_s9_a3      <= n_s9_a3;
            r_s9_hour    <= r_s8_hour;
            r_s9_minute  <= n_s9_minute;
            r_s9_second  <= n_s9_second;

            r_s10_cent   <= r_s9_cent;
            r_s10_yr4    <= r_s9_yr4;
            r_s10_a3     <= r_s9_a3;
            r_s10_mx     <= n_s10_mx;
            r_s10_mo0    <= n_s10_mo0;
            r_s10_hour   <= r_s9_hour;
            r_s10_minute <= r_s9_minute;
            r_s10_second <= r_s9_second;

            r_s11_cent   <= r_s10_cent;
            r_s11_yr4    <= r_s10_yr4;
            r_s11_a3     <= r_s10_a3;
            r_s11_mo0    <= r_s10_mo0;
            r_s11_mr0    <= n_s11_mr0;
            r_s11_hour   <= r_s10_hour;
            r_s11_minute <= r_s10_minute;
            r_s11_second <= r_s10_second;

            r_s12_cent   <= r_s11_cent;
            r_s12_yr4    <= r_s11_yr4;
            r_s12_a3     <= r_s11_a3;
            r_s12_mo     <= n_s12_mo;
            r_s12_hour   <= r_s11_hour;
            r_s12_minute <= r_s11_minute;
            r_s12_second <= r_s11_second;

            r_second     <= r_s12_second;
            r_minute     <= r_s12_minute;
            r_hour       <= r_s12_hour;
            r_day        <= n_day;
            r_month      <= n_month;
            r_year       <= n_year;
            r_rtc        <= n_rtc;
        end
    end

    // Output register drives the result ports.
    assign o_second_of_minute = r_second;
    assign o_minute_of_hour   = r_minute;
    assign o_hour_of_day      = r_hour;
    assign o_day_of_month     = r_day;
    assign o_month_of_year    = r_month;
    assign o_full_year        = r_year;
    assign o_rtc_year         = r_rtc;

endmodule

`default_nettype wire

>>> tb/tb_seconds_to_calendar_date_top.sv
// Self-checking testbench for the seconds-to-calendar-date converter. Depends on s2cd_pkg.
// Sends count words through the valid/ready input, takes each date and time from the
// directed table or its own integer Julian-day calculation and checks every output word.
module tb_seconds_to_calendar_date_top;
    import s2cd_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 400000;
    localparam int unsigned RANDOM_PER_PHASE = 175;
    localparam int unsigned MAX_REPORTS      = 10;
    localparam int unsigned NUM_PHASES       = 4;

    // Calendar constants for the date calculation.
    localparam int unsigned SECONDS_PER_DAY  = 86400;
    localparam int unsigned SECONDS_PER_HOUR = 3600;
    localparam int unsigned EPOCH_JULIAN_DAY = 2451545;
    localparam int unsigned JULIAN_OFFSET    = 32044;
    localparam int unsigned GREG_CYCLE_DAYS  = 146097;
    localparam int unsigned QUAD_YEAR_DAYS   = 1461;
    localparam int unsigned YEAR_OFFSET      = 4800;
    localparam int unsigned RTC_EPOCH_YEAR   = 2000;

    typedef struct packed {
        logic [5:0]  second_of_minute;
        logic [5:0]  minute_of_hour;
        logic [4:0]  hour_of_day;
        logic [4:0]  day_of_month;
        logic [3:0]  month_of_year;
        logic [11:0] full_year;
        logic [7:0]  rtc_year;
    } cal_date_t;

    typedef struct packed {
        logic [31:0] seconds_count;
        cal_date_t   date;
    } conv_job_t;

    typedef struct packed {
        logic [31:0] seconds_count;
        logic        known;
        cal_date_t   date;
    } directed_row_t;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [31:0] i_seconds_count = '0;
    logic        i_out_ready     = 1'b0;
    wire         o_in_ready;
    wire         o_out_valid;
    wire  [5:0]  o_second_of_minute;
    wire  [5:0]  o_minute_of_hour;
    wire  [4:0]  o_hour_of_day;
    wire  [4:0]  o_day_of_month;
    wire  [3:0]  o_month_of_year;
    wire  [11:0] o_full_year;
    wire  [7:0]  o_rtc_year;

    conv_job_t     pending_jobs [$];
    cal_date_t     expected_dates [$];
    directed_row_t directed_rows [$];
    conv_job_t     held_job;
    bit            run_enable      = 1'b0;
    int unsigned   idle_pct        = 0;
    int unsigned   stall_pct       = 0;
    int unsigned   cycle_count     = 0;
    int unsigned   words_accepted  = 0;
    int unsigned   dates_checked   = 0;
    int unsigned   failures        = 0;

    seconds_to_calendar_date_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_seconds_count    (i_seconds_count),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day),
        .o_day_of_month     (o_day_of_month),
        .o_month_of_year    (o_month_of_year),
        .o_full_year        (o_full_year),
        .o_rtc_year         (o_rtc_year)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Date and time of day for a count, by the integer Julian-day algorithm.
    function automatic cal_date_t calc_date(input logic [31:0] secs);
        cal_date_t   d;
        int unsigned jday;
        int unsigned cycles400;
        int unsigned cycles4;
        int unsigned march_mon;
        int unsigned year_num;
        jday      = secs / SECONDS_PER_DAY + JULIAN_OFFSET + EPOCH_JULIAN_DAY;
        cycles400 = (4 * jday + 3) / GREG_CYCLE_DAYS;
        jday      = jday - (GREG_CYCLE_DAYS * cycles400) / 4;
        cycles4   = (4 * jday + 3) / QUAD_YEAR_DAYS;
        jday      = jday - (QUAD_YEAR_DAYS * cycles4) / 4;
        march_mon = (5 * jday + 2) / 153;
        year_num  = 100 * cycles400 + cycles4 + march_mon / 10 - YEAR_OFFSET;
        d.second_of_minute = 6'(secs % 60);
        d.minute_of_hour   = 6'((secs / 60) % 60);
        d.hour_of_day      = 5'((secs / SECONDS_PER_HOUR) % 24);
        d.day_of_month     = 5'(jday - (153 * march_mon + 2) / 5 + 1);
        d.month_of_year    = 4'(march_mon + 3 - 12 * (march_mon / 10));
        d.full_year        = 12'(year_num);
        d.rtc_year         = (year_num >= RTC_EPOCH_YEAR) ? 8'(year_num - RTC_EPOCH_YEAR) : 8'd0;
        return d;
    endfunction

    // Random counts, weighted toward day, hour and range boundaries.
    function automatic logic [31:0] random_count();
        int unsigned day_idx;
        day_idx = $urandom_range(0, 49709);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom();
            4:          return day_idx * SECONDS_PER_DAY;
            5:          return day_idx * SECONDS_PER_DAY + SECONDS_PER_DAY - 1;
            6:          return 32'hFFFF_FFFF - $urandom_range(0, 200000);
            7:          return $urandom_range(0, 200000);
            default:    return day_idx * SECONDS_PER_DAY
                               + $urandom_range(0, 23) * SECONDS_PER_HOUR
                               + ($urandom_range(0, 1) ? SECONDS_PER_HOUR - 1 : 0);
        endcase
    endfunction

    task automatic add_row(input logic [31:0] secs, input logic known,
                           input int unsigned yr, input int unsigned mo, input int unsigned dy,
                           input int unsigned hr, input int unsigned mi, input int unsigned sc,
                           input int unsigned rtc);
        directed_row_t row;
        row.seconds_count         = secs;
        row.known                 = known;
        row.date.full_year        = 12'(yr);
        row.date.month_of_year    = 4'(mo);
        row.date.day_of_month     = 5'(dy);
        row.date.hour_of_day      = 5'(hr);
        row.date.minute_of_hour   = 6'(mi);
        row.date.second_of_minute = 6'(sc);
        row.date.rtc_year         = 8'(rtc);
        directed_rows.push_back(row);
    endtask

    // Output checking, input word driving and receiver stalls, all sampled at the rising edge.
    always @(posedge i_clk) begin
        cal_date_t got;
        cal_date_t want;
        logic      holding;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d dates still expected",
                     cycle_count, expected_dates.size());
            $display("tb_seconds_to_calendar_date_top: errors");
            $finish;
        end else if (run_enable) begin
            // Compare an accepted output word with the oldest expected date.
            if (o_out_valid && i_out_ready) begin
                got = {o_second_of_minute, o_minute_of_hour, o_hour_of_day, o_day_of_month,
                       o_month_of_year, o_full_year, o_rtc_year};
                if (expected_dates.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("cycle %0d: output word with no date expected", cycle_count);
                end else begin
                    want = expected_dates.pop_front();
                    dates_checked++;
                    if (got !== want) begin
                        failures++;
                        if (failures <= MAX_REPORTS) begin
                            $display("cycle %0d: expected %0d-%0d-%0d %0d:%0d:%0d rtc %0d",
                                     cycle_count, want.full_year, want.month_of_year,
                                     want.day_of_month, want.hour_of_day, want.minute_of_hour,
                                     want.second_of_minute, want.rtc_year);
                            $display("    got %0d-%0d-%0d %0d:%0d:%0d rtc %0d",
                                     got.full_year, got.month_of_year, got.day_of_month,
                                     got.hour_of_day, got.minute_of_hour,
                                     got.second_of_minute, got.rtc_year);
                        end
                    end
                end
            end

            // An accepted input word queues its date; a held word keeps its payload.
            holding = i_in_valid && !o_in_ready;
            if (i_in_valid && o_in_ready) begin
                expected_dates.push_back(held_job.date);
                words_accepted++;
            end
            if (!holding) begin
                if (pending_jobs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    held_job = pending_jobs.pop_front();
                    i_in_valid      <= 1'b1;
                    i_seconds_count <= held_job.seconds_count;
                end else begin
                    i_in_valid      <= 1'b0;
                    i_seconds_count <= $urandom();
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Reset, then the directed table and four phases of random words with different idle and stall rates.
    initial begin
        conv_job_t job;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_enable = 1'b1;

        // Range ends, unit rollovers, leap days (2000 and 2004), the skipped leap day of 2100
        // and the last years of the range.
        add_row(32'd0,          1'b1, 2000,  1,  1,  0,  0,  0,   0);
        add_row(32'd59,         1'b1, 2000,  1,  1,  0,  0, 59,   0);
        add_row(32'd60,         1'b1, 2000,  1,  1,  0,  1,  0,   0);
        add_row(32'd3599,       1'b1, 2000,  1,  1,  0, 59, 59,   0);
        add_row(32'd3600,       1'b1, 2000,  1,  1,  1,  0,  0,   0);
        add_row(32'd86399,      1'b1, 2000,  1,  1, 23, 59, 59,   0);
        add_row(32'd86400,      1'b1, 2000,  1,  2,  0,  0,  0,   0);
        add_row(32'd5097600,    1'b1, 2000,  2, 29,  0,  0,  0,   0);
        add_row(32'd5183999,    1'b1, 2000,  2, 29, 23, 59, 59,   0);
        add_row(32'd5184000,    1'b1, 2000,  3,  1,  0,  0,  0,   0);
        add_row(32'd31622399,   1'b1, 2000, 12, 31, 23, 59, 59,   0);
        add_row(32'd31622400,   1'b1, 2001,  1,  1,  0,  0,  0,   1);
        add_row(32'd131328000,  1'b0, 0, 0, 0, 0, 0, 0, 0);
        add_row(32'd131414400,  1'b0, 0, 0, 0, 0, 0, 0, 0);
        add_row(32'd3160857599, 1'b0, 0, 0, 0, 0, 0, 0, 0);
        add_row(32'd3160857600, 1'b0, 0, 0, 0, 0, 0, 0, 0);
        add_row(32'h7FFF_FFFF,  1'b0, 0, 0, 0, 0, 0, 0, 0);
        add_row(32'h8000_0000,  1'b0, 0, 0, 0, 0, 0, 0, 0);
        add_row(32'h5555_5555,  1'b0, 0, 0, 0, 0, 0, 0, 0);
        add_row(32'hAAAA_AAAA,  1'b0, 0, 0, 0, 0, 0, 0, 0);
        add_row(32'd4291747199, 1'b1, 2135, 12, 31, 23, 59, 59, 135);
        add_row(32'd4291747200, 1'b1, 2136,  1,  1,  0,  0,  0, 136);
        add_row(32'hFFFF_FFFF,  1'b1, 2136,  2,  7,  6, 28, 15, 136);

        for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 72; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            if (phase == 0) begin
                foreach (directed_rows[i]) begin
                    job.seconds_count = directed_rows[i].seconds_count;
                    job.date = directed_rows[i].known ? directed_rows[i].date
                                                      : calc_date(directed_rows[i].seconds_count);
                    pending_jobs.push_back(job);
                end
            end
            for (int unsigned n = 0; n < RANDOM_PER_PHASE; n++) begin
                job.seconds_count = random_count();
                job.date          = calc_date(job.seconds_count);
                pending_jobs.push_back(job);
            end
            while (pending_jobs.size() != 0 || i_in_valid || expected_dates.size() != 0)
                @(negedge i_clk);
        end

        // Let the pipeline run out, then settle the verdict.
        repeat (NUM_STAGES + 4) @(negedge i_clk);
        if (expected_dates.size() != 0) begin
            $display("%0d expected dates never arrived", expected_dates.size());
            failures += expected_dates.size();
        end
        $display("covered %0d count words (%0d from the directed table) over %0d idle phases",
                 words_accepted, directed_rows.size(), NUM_PHASES);
        $display("checked %0d dates, %0d failures", dates_checked, failures);
        if (failures == 0) begin
            $display("tb_seconds_to_calendar_date_top: clean");
        end else begin
            $display("tb_seconds_to_calendar_date_top: errors");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/s2cd_pkg.sv
hw/rtl/s2cd_pipe_ctrl.sv
hw/rtl/seconds_to_calendar_date_top.sv
tb/tb_seconds_to_calendar_date_top.sv
